// ----- rtl/fbsb_pkg.sv -----
// Shared types and constants for the fit-box scaled blit address generator.
// Used by every module of the block; depends on nothing else.
package fbsb_pkg;

    // Scaling geometry
    localparam int BOX_SIZE  = 64;
    localparam int FRAC_BITS = 10;

    // Field widths
    localparam int DIM_W  = 11;                       // texture size
    localparam int POS_W  = 12;                       // signed screen position
    localparam int CFG_W  = 12;                       // screen size registers
    localparam int FB_W   = 22;                       // framebuffer index
    localparam int TEX_W  = 20;                       // texel index
    localparam int ACC_W  = 32;                       // texture coordinate accumulators
    localparam int SIDE_W = $clog2(BOX_SIZE + 1);     // box side and pixel indexes
    localparam int NUM_W  = DIM_W + FRAC_BITS;        // dividend and step width
    localparam int RES_W  = NUM_W + DIM_W;            // product width
    localparam int CLIP_W = CFG_W + 2;                // signed clipping arithmetic

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 12'd320;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 12'd240;

    // Item function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef struct packed {
        logic                    func;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [DIM_W-1:0]        tex_width;
        logic [DIM_W-1:0]        tex_height;
    } in_item_t;

    typedef struct packed {
        logic             pixel_valid;
        logic [FB_W-1:0]  fb_addr;
        logic [TEX_W-1:0] tex_addr;
        logic             last_pixel;
    } out_item_t;

    typedef enum logic {
        ALU_DIV,
        ALU_MUL
    } alu_op_t;

    typedef enum logic [3:0] {
        SETUP_IDLE,
        SETUP_FIT_DIV,
        SETUP_FIT_MUL,
        SETUP_COL_DIV,
        SETUP_ROW_DIV,
        SETUP_CLIP,
        SETUP_COL_MUL,
        SETUP_ROW_MUL,
        SETUP_FB_MUL,
        SETUP_LOAD
    } setup_state_t;

    // Draw parameters handed from the setup sequencer to the pixel walker
    typedef struct packed {
        logic              active;
        logic [SIDE_W-1:0] col_start;
        logic [SIDE_W-1:0] col_end;
        logic [SIDE_W-1:0] row_start;
        logic [SIDE_W-1:0] row_end;
        logic [NUM_W-1:0]  step_col;
        logic [NUM_W-1:0]  step_row;
        logic [ACC_W-1:0]  tex_col_acc;
        logic [ACC_W-1:0]  tex_row_start;
        logic [FB_W-1:0]   fb_base;
        logic [DIM_W-1:0]  tex_height;
    } draw_setup_t;

endpackage

// ----- rtl/fbsb_alu.sv -----
// Shared bit-serial arithmetic unit: restoring divide and shift-add multiply.
// Depends on fbsb_pkg.
module fbsb_alu (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  fbsb_pkg::alu_op_t          op,
    input  logic [fbsb_pkg::NUM_W-1:0] a,
    input  logic [fbsb_pkg::DIM_W-1:0] b,
    output logic                       done,
    output logic [fbsb_pkg::NUM_W-1:0] quot,
    output logic [fbsb_pkg::RES_W-1:0] prod
);
    import fbsb_pkg::*;

    localparam int ITER_W = $clog2(NUM_W + 1);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    alu_op_t           op_reg,    op_next;
    logic [ITER_W-1:0] cnt_reg,   cnt_next;
    logic [NUM_W-1:0]  q_reg,     q_next;
    logic [RES_W-1:0]  acc_reg,   acc_next;
    logic [NUM_W-1:0]  opnd_reg,  opnd_next;

    logic              top_bit;
    logic [DIM_W:0]    rem_sh;
    logic [DIM_W+1:0]  diff;
    logic              fits;
    logic [RES_W-1:0]  mul_sum;

    // One quotient bit or one multiplier bit per cycle, MSB first
    assign top_bit = q_reg[NUM_W-1];
    assign rem_sh  = {acc_reg[DIM_W-1:0], top_bit};
    assign diff    = {1'b0, rem_sh} - {2'b00, opnd_reg[DIM_W-1:0]};
    assign fits    = !diff[DIM_W+1];
    assign mul_sum = {acc_reg[RES_W-2:0], 1'b0} + (top_bit ? RES_W'(opnd_reg) : '0);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        acc_next  = acc_reg;
        opnd_next = opnd_reg;
        if (start) begin
            // Load operands
            busy_next = 1'b1;
            op_next   = op;
            acc_next  = '0;
            case (op)
                ALU_DIV: begin
                    q_next    = a;
                    opnd_next = NUM_W'(b);
                    cnt_next  = ITER_W'(NUM_W);
                end
                ALU_MUL: begin
                    q_next    = {b, {(NUM_W-DIM_W){1'b0}}};
                    opnd_next = a;
                    cnt_next  = ITER_W'(DIM_W);
                end
                default: begin
                    q_next    = a;
                    opnd_next = NUM_W'(b);
                    cnt_next  = ITER_W'(NUM_W);
                end
            endcase
        end else if (busy_reg) begin
            // Advance one step
            case (op_reg)
                ALU_DIV: begin
                    acc_next = fits ? RES_W'(diff[DIM_W:0]) : RES_W'(rem_sh);
                    q_next   = {q_reg[NUM_W-2:0], fits};
                end
                ALU_MUL: begin
                    acc_next = mul_sum;
                    q_next   = {q_reg[NUM_W-2:0], 1'b0};
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
        opnd_reg <= opnd_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign prod = acc_reg;

endmodule

// ----- rtl/fbsb_setup.sv -----
// Draw setup sequencer: box fit, steps, clip window and start addresses.
// Drives the shared unit in fbsb_alu; depends on fbsb_pkg.
module fbsb_setup (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  fbsb_pkg::in_item_t         item,
    input  logic [fbsb_pkg::CFG_W-1:0] screen_width,
    input  logic [fbsb_pkg::CFG_W-1:0] screen_height,
    output logic                       busy,
    output logic                       load_valid,
    output fbsb_pkg::draw_setup_t      setup
);
    import fbsb_pkg::*;

    setup_state_t state_reg, state_next;

    logic                    issued_reg;
    logic                    ok_reg;
    logic signed [POS_W-1:0] x_reg, y_reg;
    logic [DIM_W-1:0]        w_reg, h_reg;
    logic [SIDE_W-1:0]       fw_reg, fh_reg;
    logic [NUM_W-1:0]        step_col_reg, step_row_reg;
    logic [SIDE_W-1:0]       col_start_reg, col_end_reg, row_start_reg, row_end_reg;
    logic [ACC_W-1:0]        tex_col_acc_reg, tex_row_start_reg;
    logic [FB_W-1:0]         fb_base_reg;

    logic              alu_start, alu_done;
    alu_op_t           alu_op;
    logic [NUM_W-1:0]  alu_a, alu_quot;
    logic [DIM_W-1:0]  alu_b;
    logic [RES_W-1:0]  alu_prod;
    logic              op_state;

    logic              wide;
    logic [DIM_W-1:0]  small_dim, big_dim;
    logic [SIDE_W-1:0] fit;

    logic signed [CLIP_W-1:0] x_ext, y_ext, fw_ext, fh_ext, sw_ext, sh_ext;
    logic signed [CLIP_W-1:0] sx, sy, ex, ey;
    logic                     clip_empty;
    logic [DIM_W-1:0]         x0, y0;

    fbsb_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (alu_start),
        .op      (alu_op),
        .a       (alu_a),
        .b       (alu_b),
        .done    (alu_done),
        .quot    (alu_quot),
        .prod    (alu_prod)
    );

    // Box fit: the wider texture side maps onto the full box
    assign wide      = w_reg > h_reg;
    assign small_dim = wide ? h_reg : w_reg;
    assign big_dim   = wide ? w_reg : h_reg;
    assign fit       = alu_prod[FRAC_BITS +: SIDE_W];

    // Clip window against the screen
    assign x_ext  = CLIP_W'(x_reg);
    assign y_ext  = CLIP_W'(y_reg);
    assign fw_ext = CLIP_W'(fw_reg);
    assign fh_ext = CLIP_W'(fh_reg);
    assign sw_ext = CLIP_W'(screen_width);
    assign sh_ext = CLIP_W'(screen_height);
    assign sx     = x_reg[POS_W-1] ? -x_ext : '0;
    assign sy     = y_reg[POS_W-1] ? -y_ext : '0;
    assign ex     = (x_ext + fw_ext > sw_ext) ? sw_ext - x_ext : fw_ext;
    assign ey     = (y_ext + fh_ext > sh_ext) ? sh_ext - y_ext : fh_ext;
    assign clip_empty = (sx >= ex) || (sy >= ey);
    assign x0     = x_reg[POS_W-1] ? '0 : x_reg[DIM_W-1:0];
    assign y0     = y_reg[POS_W-1] ? '0 : y_reg[DIM_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SETUP_IDLE: begin
                if (start) begin
                    if (item.tex_width == '0 || item.tex_height == '0) begin
                        state_next = SETUP_LOAD;
                    end else begin
                        state_next = SETUP_FIT_DIV;
                    end
                end
            end
            SETUP_FIT_DIV: begin
                if (alu_done) state_next = SETUP_FIT_MUL;
            end
            SETUP_FIT_MUL: begin
                if (alu_done) state_next = (fit == '0) ? SETUP_LOAD : SETUP_COL_DIV;
            end
            SETUP_COL_DIV: begin
                if (alu_done) state_next = SETUP_ROW_DIV;
            end
            SETUP_ROW_DIV: begin
                if (alu_done) state_next = SETUP_CLIP;
            end
            SETUP_CLIP: begin
                state_next = clip_empty ? SETUP_LOAD : SETUP_COL_MUL;
            end
            SETUP_COL_MUL: begin
                if (alu_done) state_next = SETUP_ROW_MUL;
            end
            SETUP_ROW_MUL: begin
                if (alu_done) state_next = SETUP_FB_MUL;
            end
            SETUP_FB_MUL: begin
                if (alu_done) state_next = SETUP_LOAD;
            end
            SETUP_LOAD: begin
                state_next = SETUP_IDLE;
            end
            default: begin
                state_next = SETUP_IDLE;
            end
        endcase
    end

    // Outputs and operand selection
    always_comb begin
        op_state   = 1'b0;
        alu_op     = ALU_DIV;
        alu_a      = '0;
        alu_b      = '0;
        load_valid = 1'b0;
        busy       = state_reg != SETUP_IDLE;
        case (state_reg)
            SETUP_FIT_DIV: begin
                op_state = 1'b1;
                alu_a    = {small_dim, FRAC_BITS'(0)};
                alu_b    = big_dim;
            end
            SETUP_FIT_MUL: begin
                op_state = 1'b1;
                alu_op   = ALU_MUL;
                alu_a    = alu_quot;
                alu_b    = DIM_W'(BOX_SIZE);
            end
            SETUP_COL_DIV: begin
                op_state = 1'b1;
                alu_a    = {w_reg, FRAC_BITS'(0)};
                alu_b    = DIM_W'(fw_reg);
            end
            SETUP_ROW_DIV: begin
                op_state = 1'b1;
                alu_a    = {h_reg, FRAC_BITS'(0)};
                alu_b    = DIM_W'(fh_reg);
            end
            SETUP_COL_MUL: begin
                op_state = 1'b1;
                alu_op   = ALU_MUL;
                alu_a    = step_col_reg;
                alu_b    = DIM_W'(col_start_reg);
            end
            SETUP_ROW_MUL: begin
                op_state = 1'b1;
                alu_op   = ALU_MUL;
                alu_a    = step_row_reg;
                alu_b    = DIM_W'(row_start_reg);
            end
            SETUP_FB_MUL: begin
                op_state = 1'b1;
                alu_op   = ALU_MUL;
                alu_a    = NUM_W'(screen_width);
                alu_b    = y0;
            end
            SETUP_LOAD: begin
                load_valid = 1'b1;
            end
            default: begin
                op_state = 1'b0;
            end
        endcase
    end

    // Issue one operation on entry to each arithmetic state
    assign alu_start = op_state && !issued_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= SETUP_IDLE;
            issued_reg <= 1'b0;
            ok_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (alu_start) begin
                issued_reg <= 1'b1;
            end else if (alu_done) begin
                issued_reg <= 1'b0;
            end
            if (start) begin
                ok_reg <= 1'b0;
            end else if (state_reg == SETUP_FB_MUL && alu_done) begin
                ok_reg <= 1'b1;
            end
        end
    end

    // Capture the item and hold intermediate results
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= item.pos_x;
            y_reg <= item.pos_y;
            w_reg <= item.tex_width;
            h_reg <= item.tex_height;
        end
        if (alu_done) begin
            case (state_reg)
                SETUP_FIT_MUL: begin
                    fw_reg <= wide ? SIDE_W'(BOX_SIZE) : fit;
                    fh_reg <= wide ? fit : SIDE_W'(BOX_SIZE);
                end
                SETUP_COL_DIV: step_col_reg      <= alu_quot;
                SETUP_ROW_DIV: step_row_reg      <= alu_quot;
                SETUP_COL_MUL: tex_col_acc_reg   <= ACC_W'(alu_prod);
                SETUP_ROW_MUL: tex_row_start_reg <= ACC_W'(alu_prod);
                SETUP_FB_MUL:  fb_base_reg       <= FB_W'(alu_prod + RES_W'(x0));
                default: begin
                    fb_base_reg <= fb_base_reg;
                end
            endcase
        end
        if (state_reg == SETUP_CLIP) begin
            col_start_reg <= SIDE_W'(sx);
            col_end_reg   <= SIDE_W'(ex);
            row_start_reg <= SIDE_W'(sy);
            row_end_reg   <= SIDE_W'(ey);
        end
    end

    always_comb begin
        setup.active        = ok_reg;
        setup.col_start     = col_start_reg;
        setup.col_end       = col_end_reg;
        setup.row_start     = row_start_reg;
        setup.row_end       = row_end_reg;
        setup.step_col      = step_col_reg;
        setup.step_row      = step_row_reg;
        setup.tex_col_acc   = tex_col_acc_reg;
        setup.tex_row_start = tex_row_start_reg;
        setup.fb_base       = fb_base_reg;
        setup.tex_height    = h_reg;
    end

endmodule

// ----- rtl/fbsb_walk.sv -----
// Pixel walker: steps column by column through the clipped box and forms
// framebuffer and texel addresses. Depends on fbsb_pkg.
module fbsb_walk (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load_valid,
    input  fbsb_pkg::draw_setup_t      setup,
    input  logic                       step,
    input  logic [fbsb_pkg::CFG_W-1:0] screen_width,
    output fbsb_pkg::out_item_t        result
);
    import fbsb_pkg::*;

    logic              active_reg;
    logic [SIDE_W-1:0] col_idx_reg, col_end_reg;
    logic [SIDE_W-1:0] row_idx_reg, row_start_reg, row_end_reg;
    logic [ACC_W-1:0]  col_acc_reg, row_acc_reg, row_acc_start_reg;
    logic [NUM_W-1:0]  step_col_reg, step_row_reg;
    logic [FB_W-1:0]   fb_base_reg, fb_cur_reg;
    logic [DIM_W-1:0]  tex_h_reg;

    logic [SIDE_W-1:0]      col_inc, row_inc;
    logic                   col_done;
    logic [TEX_W+DIM_W-1:0] tex_prod;
    logic [TEX_W-1:0]       tex_addr;

    assign col_inc  = col_idx_reg + 1'b1;
    assign row_inc  = row_idx_reg + 1'b1;
    assign col_done = row_inc >= row_end_reg;

    // Texel index from the integer parts of both coordinates
    assign tex_prod = col_acc_reg[FRAC_BITS +: TEX_W] * tex_h_reg;
    assign tex_addr = TEX_W'(tex_prod) + row_acc_reg[FRAC_BITS +: TEX_W];

    always_comb begin
        result = '0;
        if (active_reg) begin
            result.pixel_valid = 1'b1;
            result.fb_addr     = fb_cur_reg;
            result.tex_addr    = tex_addr;
            result.last_pixel  = (col_inc == col_end_reg) && (row_inc == row_end_reg);
        end
    end

    // Load a new draw, or advance down the column and wrap to the next one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (load_valid) begin
            active_reg <= setup.active;
        end else if (step && active_reg && col_done && (col_inc >= col_end_reg)) begin
            active_reg <= 1'b0;
        end

        if (load_valid) begin
            col_idx_reg       <= setup.col_start;
            col_end_reg       <= setup.col_end;
            row_idx_reg       <= setup.row_start;
            row_start_reg     <= setup.row_start;
            row_end_reg       <= setup.row_end;
            col_acc_reg       <= setup.tex_col_acc;
            row_acc_reg       <= setup.tex_row_start;
            row_acc_start_reg <= setup.tex_row_start;
            step_col_reg      <= setup.step_col;
            step_row_reg      <= setup.step_row;
            fb_base_reg       <= setup.fb_base;
            fb_cur_reg        <= setup.fb_base;
            tex_h_reg         <= setup.tex_height;
        end else if (step && active_reg) begin
            if (col_done) begin
                col_idx_reg <= col_inc;
                row_idx_reg <= row_start_reg;
                col_acc_reg <= col_acc_reg + ACC_W'(step_col_reg);
                row_acc_reg <= row_acc_start_reg;
                fb_base_reg <= fb_base_reg + 1'b1;
                fb_cur_reg  <= fb_base_reg + 1'b1;
            end else begin
                row_idx_reg <= row_inc;
                row_acc_reg <= row_acc_reg + ACC_W'(step_row_reg);
                fb_cur_reg  <= fb_cur_reg + FB_W'(screen_width);
            end
        end
    end

endmodule

// ----- rtl/fit_box_scaled_blit_address_gen_top.sv -----
// Top level of the fit-box scaled blit address generator.
// Depends on fbsb_pkg, fbsb_setup (with fbsb_alu) and fbsb_walk.
//
// A start item (func 0) fits the column-major texture into a 64-pixel box
// with its aspect ratio kept, computes 10-bit fraction steps and clips the
// box against the screen at the signed position; it returns no item. Each
// step item (func 1) returns one item with the next framebuffer and texel
// address, walking down each column and then across, with last_pixel set
// on the final pixel; outside a draw the item has pixel_valid 0 and all
// fields zero. Step items are taken one per cycle while no setup runs and
// the output is not stalled. A start item holds s_ready low for its setup
// sequence on a single bit-serial arithmetic unit: three 21-step divides and
// four 11-step multiplies (issue, steps, done), one after another, plus a
// clip state and a load state. An empty draw ends early: a zero texture size
// goes straight to the load state, a box side that rounds to zero ends after
// the fit multiply and a fully clipped box after the clip state. The user
// must write screen_width and screen_height through the cfg port only while
// no item is in flight; the block itself does not enforce this.
module fit_box_scaled_blit_address_gen_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  fbsb_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output fbsb_pkg::out_item_t            m_data,
    input  logic                           cfg_wr_en,
    input  logic [fbsb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbsb_pkg::CFG_W-1:0]     cfg_wr_data
);
    import fbsb_pkg::*;

    logic [CFG_W-1:0] screen_width_reg, screen_height_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic        s_accept, start_accept, step_accept;
    logic        setup_busy, load_valid;
    draw_setup_t setup;
    out_item_t   walk_result;

    // Take items while no setup runs and the output slot is free or draining
    assign s_ready      = !setup_busy && (!m_valid_reg || m_ready);
    assign s_accept     = s_valid && s_ready;
    assign start_accept = s_accept && (s_data.func == FUNC_START);
    assign step_accept  = s_accept && (s_data.func == FUNC_STEP);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wr_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wr_data;
                default: begin
                    screen_width_reg <= screen_width_reg;
                end
            endcase
        end
    end

    fbsb_setup u_setup (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (start_accept),
        .item          (s_data),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .busy          (setup_busy),
        .load_valid    (load_valid),
        .setup         (setup)
    );

    fbsb_walk u_walk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_valid   (load_valid),
        .setup        (setup),
        .step         (step_accept),
        .screen_width (screen_width_reg),
        .result       (walk_result)
    );

    // Output register: hold until taken, refill on each step item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (step_accept) begin
            m_data_reg <= walk_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
